[hdl/dtpah_pkg.sv]
// Shared types and constants for the dual triac phase-angle heater.
// No dependencies; imported by the front, back and top modules and by the bench.
`timescale 1ns / 1ps

package dtpah_pkg;

  localparam int RES_W       = 16;    // PT100 resistance, 1/16 ohm
  localparam int SP_W        = 14;    // setpoint, 1/16 degC
  localparam int TEMP_W      = 19;    // temperature, 1/16 degC, signed
  localparam int DIFF_W      = 20;    // 2*sp - 5*(R - 100 ohm), 1/32 degC, signed
  localparam int RAMP_W      = 9;     // clamped ramp distance, 0..RAMP_SPAN
  localparam int RAMP_SPAN   = 320;   // 10 degC in 1/32 degC
  localparam int MIN_DELAY   = 10;
  localparam int R0_OFFSET   = 8000;  // 5 * (100 ohm in 1/16 ohm)
  localparam int TEMP_OFFSET = 4000;  // 100 ohm * 2.5 in 1/16 degC

  // ceil(2^22 / 5): floor(m * RECIP_FIVE / 2^22) == floor(m / 5) for m < 2^22
  localparam int               RECIP_SHIFT = 22;
  localparam logic [19:0]      RECIP_FIVE  = 20'd838861;

  localparam int Q_DEPTH = 4;

  // Configuration register indexes
  localparam logic CFG_OIL_SP   = 1'b0;
  localparam logic CFG_WATER_SP = 1'b1;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_ZERO   = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic [SP_W-1:0] water_sp;
    logic [SP_W-1:0] oil_sp;
  } cfg_t;

  // Classified beat handed from front to back; index 0 oil, 1 water
  typedef struct packed {
    action_t                  action;
    logic [1:0]               on;
    logic [1:0][TEMP_W-1:0]   temp;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

endpackage

[hdl/dtpah_front.sv]
// Front end: accepts beats, converts resistances, works out on flags and firing delays.
// Three-stage pipeline; depends on dtpah_pkg.
`timescale 1ns / 1ps

module dtpah_front #(
  parameter int MAX_DELAY = 10000,
  parameter int DLY_W     = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  dtpah_pkg::action_t                     in_action,
  input  logic [1:0][dtpah_pkg::RES_W-1:0]       in_res,
  input  dtpah_pkg::cfg_t                        cfg,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output dtpah_pkg::item_t                       out_item,
  output logic [1:0][DLY_W-1:0]                  out_delay
);
  import dtpah_pkg::*;

  localparam int PROD_W = $clog2(RAMP_SPAN * MAX_DELAY + 1);
  localparam int N_W    = PROD_W - 5;
  localparam int M_W    = N_W + 1;
  localparam int Q_W    = M_W + 20 - RECIP_SHIFT;

  typedef enum logic [1:0] {
    CLS_MAX  = 2'd0,
    CLS_MIN  = 2'd1,
    CLS_RAMP = 2'd2
  } dly_cls_t;

  logic [2:0]               vld_r;
  logic                     adv;

  item_t                    s1_item_r, s1_item_nxt;
  dly_cls_t [1:0]           s1_cls_r,  s1_cls_nxt;
  logic [1:0][RAMP_W-1:0]   s1_d_r,    s1_d_nxt;

  item_t                    s2_item_r;
  dly_cls_t [1:0]           s2_cls_r;
  logic [1:0][PROD_W-1:0]   s2_p_r,    s2_p_nxt;

  item_t                    s3_item_r;
  logic [1:0][DLY_W-1:0]    s3_dly_r,  s3_dly_nxt;

  logic [1:0][SP_W-1:0]     sp;
  logic [1:0][18:0]         r5;
  logic [1:0][18:0]         t5;
  logic [1:0][DIFF_W-1:0]   diff;
  logic [1:0][PROD_W:0]     p_sum;
  logic [1:0][N_W-1:0]      n_q;
  logic [1:0][M_W-1:0]      m_q;
  logic [1:0][M_W+19:0]     recip_prod;
  logic [1:0][Q_W-1:0]      q_q;

  assign adv       = !vld_r[2] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[2];
  assign out_item  = s3_item_r;
  assign out_delay = s3_dly_r;
  assign sp[0]     = cfg.oil_sp;
  assign sp[1]     = cfg.water_sp;

  // Stage 1: temperature, sign of the distance to setpoint, delay class
  always_comb begin
    s1_item_nxt.action = in_action;
    for (int c = 0; c < 2; c++) begin
      r5[c]   = {1'b0, in_res[c], 2'b00} + {3'b000, in_res[c]};
      t5[c]   = r5[c] + 19'd1;
      diff[c] = DIFF_W'($signed({5'd0, sp[c], 1'b0}) - $signed({1'b0, r5[c]})
                + $signed(DIFF_W'(R0_OFFSET)));
      s1_item_nxt.temp[c] = {1'b0, t5[c][18:1]} - TEMP_W'(TEMP_OFFSET);
      s1_item_nxt.on[c]   = !diff[c][DIFF_W-1];
      s1_d_nxt[c]         = diff[c][RAMP_W-1:0];
      if (diff[c][DIFF_W-1]) begin
        s1_cls_nxt[c] = CLS_MAX;
      end else if ($signed(diff[c]) > $signed(DIFF_W'(RAMP_SPAN))) begin
        s1_cls_nxt[c] = CLS_MIN;
      end else begin
        s1_cls_nxt[c] = CLS_RAMP;
      end
    end
  end

  // Stage 2: distance times full delay
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      s2_p_nxt[c] = PROD_W'({{(PROD_W-RAMP_W){1'b0}}, s1_d_r[c]} * PROD_W'(MAX_DELAY));
    end
  end

  // Stage 3: ceil(p / 320) as ceil(ceil(p / 64) / 5), then the ramp
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      p_sum[c]      = {1'b0, s2_p_r[c]} + (PROD_W+1)'(63);
      n_q[c]        = p_sum[c][PROD_W:6];
      m_q[c]        = {1'b0, n_q[c]} + M_W'(4);
      recip_prod[c] = {20'd0, m_q[c]} * {{M_W{1'b0}}, RECIP_FIVE};
      q_q[c]        = recip_prod[c][M_W+19:RECIP_SHIFT];
      unique case (s2_cls_r[c])
        CLS_MAX:  s3_dly_nxt[c] = DLY_W'(MAX_DELAY);
        CLS_MIN:  s3_dly_nxt[c] = DLY_W'(MIN_DELAY);
        CLS_RAMP: s3_dly_nxt[c] = DLY_W'(MAX_DELAY + MIN_DELAY) - DLY_W'(q_q[c]);
        default:  s3_dly_nxt[c] = DLY_W'(MAX_DELAY);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= s1_item_nxt;
      s1_cls_r  <= s1_cls_nxt;
      s1_d_r    <= s1_d_nxt;
      s2_item_r <= s1_item_r;
      s2_cls_r  <= s1_cls_r;
      s2_p_r    <= s2_p_nxt;
      s3_item_r <= s2_item_r;
      s3_dly_r  <= s3_dly_nxt;
    end
  end

endmodule

[hdl/dtpah_fifo.sv]
// Short queue between front and back end of the heater controller.
// Register-based, first word fall-through; depends on nothing else.
`timescale 1ns / 1ps

module dtpah_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/dtpah_back.sv]
// Back end: channel state, zero-cross start, tick countdown, gate firing, result register.
// Depends on dtpah_pkg.
`timescale 1ns / 1ps

module dtpah_back #(
  parameter int DLY_W = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  dtpah_pkg::item_t                       q_item,
  input  logic [1:0][DLY_W-1:0]                  q_delay,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             out_relay,
  output logic [1:0]                             out_gate,
  output logic                                   out_zde,
  output logic [1:0][dtpah_pkg::TEMP_W-1:0]      out_temp
);
  import dtpah_pkg::*;

  logic [1:0]               on_r,    on_nxt;
  logic [1:0][DLY_W-1:0]    delay_r, delay_nxt;
  logic [1:0][DLY_W-1:0]    count_r, count_nxt;
  logic [1:0]               run_r,   run_nxt;
  logic [1:0]               gate_r,  gate_nxt;
  logic [1:0][TEMP_W-1:0]   temp_r,  temp_nxt;

  logic                     ovld_r;
  logic [1:0]               orelay_r;
  logic [1:0]               ogate_r;
  logic [1:0][TEMP_W-1:0]   otemp_r;

  assign q_pop     = !q_empty && (!ovld_r || out_ready);
  assign out_valid = ovld_r;
  assign out_relay = orelay_r;
  assign out_gate  = ogate_r;
  assign out_zde   = |orelay_r;
  assign out_temp  = otemp_r;

  always_comb begin
    on_nxt    = on_r;
    delay_nxt = delay_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    gate_nxt  = gate_r;
    temp_nxt  = temp_r;
    if (q_pop) begin
      unique case (q_item.action)
        ACT_SAMPLE: begin
          on_nxt    = q_item.on;
          delay_nxt = q_delay;
          temp_nxt  = q_item.temp;
        end
        ACT_ZERO: begin
          for (int c = 0; c < 2; c++) begin
            gate_nxt[c]  = 1'b0;
            run_nxt[c]   = on_r[c];
            count_nxt[c] = on_r[c] ? delay_r[c] : '0;
          end
        end
        ACT_TICK: begin
          for (int c = 0; c < 2; c++) begin
            if (run_r[c]) begin
              // expiry on a count of one, or a zero load
              if (count_r[c] <= DLY_W'(1)) begin
                count_nxt[c] = '0;
                run_nxt[c]   = 1'b0;
                gate_nxt[c]  = on_r[c];
              end else begin
                count_nxt[c] = count_r[c] - DLY_W'(1);
              end
            end
          end
        end
        ACT_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= '0;
      delay_r <= '0;
      count_r <= '0;
      run_r   <= '0;
      gate_r  <= '0;
      temp_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      on_r    <= on_nxt;
      delay_r <= delay_nxt;
      count_r <= count_nxt;
      run_r   <= run_nxt;
      gate_r  <= gate_nxt;
      temp_r  <= temp_nxt;
      if (q_pop) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      orelay_r <= on_nxt;
      ogate_r  <= gate_nxt;
      otemp_r  <= temp_nxt;
    end
  end

endmodule

[hdl/dual_triac_phase_angle_heater.sv]
// Dual triac phase-angle heater controller, top level (oil and water channels).
// Each accepted input beat passes the 3 front pipeline stages, the queue write and the
//   state update into the output register on its way to its result beat.
// Throughput: one beat per cycle absent back-pressure; each beat of any action gives a result.
// Reset: synchronous, active low; setpoints, channel state, queue and pipeline valids cleared.
// Depends on dtpah_pkg, dtpah_front, dtpah_fifo and dtpah_back.
`timescale 1ns / 1ps

module dual_triac_phase_angle_heater #(
  parameter int MAX_DELAY = 10000   // full firing delay in ticks, 100..60000
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] oil_resistance, [31:16] water_resistance
  input  logic [1:0]  in_tuser,    // [1:0] action

  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [0] oil_relay, [1] water_relay, [2] oil_gate,
                                   // [3] water_gate, [4] zero_detect_enable,
                                   // [23:5] oil_temperature, [42:24] water_temperature,
                                   // [47:43] zero

  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,    // 0 oil_setpoint, 1 water_setpoint
  input  logic [13:0] cfg_wdata
);
  import dtpah_pkg::*;

  // Delay counters hold up to MAX_DELAY + MIN_DELAY (top of the ramp)
  localparam int DLY_W  = $clog2(MAX_DELAY + MIN_DELAY + 1);
  localparam int QUE_W  = ITEM_W + 2 * DLY_W;

  // Setpoint registers; the user must write them only while the block is idle, the block does not enforce it
  cfg_t                     cfg_r;

  // Front end outputs
  logic                     fe_valid;
  item_t                    fe_item;
  logic [1:0][DLY_W-1:0]    fe_delay;
  logic [1:0][RES_W-1:0]    in_res;

  // Queue
  logic                     q_full;
  logic                     q_empty;
  logic                     q_pop;
  logic [QUE_W-1:0]         q_wdata;
  logic [QUE_W-1:0]         q_rdata;
  item_t                    q_item;
  logic [1:0][DLY_W-1:0]    q_delay;

  // Back end result
  logic [1:0]               be_relay;
  logic [1:0]               be_gate;
  logic                     be_zde;
  logic [1:0][TEMP_W-1:0]   be_temp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OIL_SP:   cfg_r.oil_sp   <= cfg_wdata;
        CFG_WATER_SP: cfg_r.water_sp <= cfg_wdata;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  assign in_res[0] = in_tdata[15:0];
  assign in_res[1] = in_tdata[31:16];

  // Front: conversion and delay ramp; only samples use the computed fields
  dtpah_front #(
    .MAX_DELAY (MAX_DELAY),
    .DLY_W     (DLY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (action_t'(in_tuser)),
    .in_res    (in_res),
    .cfg       (cfg_r),
    .out_valid (fe_valid),
    .out_ready (!q_full),
    .out_item  (fe_item),
    .out_delay (fe_delay)
  );

  assign q_wdata = {fe_delay, fe_item};

  // Queue decouples the front pipeline from a stalled result channel
  dtpah_fifo #(
    .WIDTH (QUE_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_valid),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  assign q_item  = q_rdata[ITEM_W-1:0];
  assign q_delay = q_rdata[QUE_W-1:ITEM_W];

  // Back: applies each beat to channel state in arrival order, one per cycle unless out_tready stalls
  dtpah_back #(
    .DLY_W (DLY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_delay   (q_delay),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_relay (be_relay),
    .out_gate  (be_gate),
    .out_zde   (be_zde),
    .out_temp  (be_temp)
  );

  assign out_tdata = {5'd0, be_temp[1], be_temp[0], be_zde,
                      be_gate[1], be_gate[0], be_relay[1], be_relay[0]};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for dual_triac_phase_angle_heater: queue-fed driver, result monitor
// and a beat-level predictor of both heater channels. Depends on dtpah_pkg and the RTL.

module tb_top;
  import dtpah_pkg::*;

  localparam int HEAT_MAX_DELAY = 10000;
  localparam int STALL_LIMIT    = 5000;   // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 12;     // extra wait once the block has gone idle
  localparam int IDLE_PCT       = 17;
  localparam int HOLD_CYCLES    = 300;    // long receiver back-pressure
  localparam int HOLD_AT        = 120;    // results seen before the hold starts
  localparam int ITEMS_PER_SET  = 230;    // random items per setpoint setting
  localparam int OIL            = 0;
  localparam int WATER          = 1;

  typedef struct {
    action_t     action;
    logic [15:0] oil_res;
    logic [15:0] water_res;
  } heater_beat_t;

  // One heater channel as the block sees it
  typedef struct {
    logic [SP_W-1:0]   sp;
    bit                on;
    logic [13:0]       delay;
    logic [13:0]       count;
    bit                running;
    bit                gate;
    logic [TEMP_W-1:0] temp;
  } chan_t;

  typedef struct {
    bit                oil_relay;
    bit                water_relay;
    bit                oil_gate;
    bit                water_gate;
    bit                zero_en;
    logic [TEMP_W-1:0] oil_temp;
    logic [TEMP_W-1:0] water_temp;
  } heater_result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // [15:0] oil_resistance, [31:16] water_resistance
  logic [1:0]  in_tuser   = '0;    // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // [0] oil_relay, [1] water_relay, [2] oil_gate,
                                   // [3] water_gate, [4] zero_detect_enable,
                                   // [23:5] oil_temperature, [42:24] water_temperature
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = CFG_OIL_SP;
  logic [13:0] cfg_wdata  = '0;

  heater_beat_t   pending_beats[$];    // stimulus not yet offered
  heater_result_t expected_results[$]; // predicted beats not yet seen
  chan_t          chan_state[2];       // predictor copy, index OIL / WATER

  int mismatches   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit calm         = 1'b0;   // no random idling on either side while set
  bit in_taken     = 1'b0;   // input beat accepted at the last rising edge

  dual_triac_phase_angle_heater #(
    .MAX_DELAY(HEAT_MAX_DELAY)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // Temperature rounds halves up; the on decision and ramp use the exact margin
  // 2*sp - 5*(R - 100 ohm), in 1/32 degC.
  function automatic chan_t apply_sample(chan_t c, logic [15:0] res);
    int margin;
    margin = 2 * int'(c.sp) - 5 * (int'(res) - 1600);
    c.temp = TEMP_W'((5 * int'(res) + 1) / 2 - TEMP_OFFSET);
    c.on   = (margin >= 0);
    if (margin < 0) begin
      c.delay = 14'(HEAT_MAX_DELAY);
    end else if (margin > RAMP_SPAN) begin
      c.delay = 14'(MIN_DELAY);
    end else begin
      // ramp, quotient rounded up: MAX + MIN - ceil(margin * MAX / span)
      c.delay = 14'(HEAT_MAX_DELAY + MIN_DELAY
                    - (margin * HEAT_MAX_DELAY + RAMP_SPAN - 1) / RAMP_SPAN);
    end
    return c;
  endfunction

  function automatic chan_t apply_zero_cross(chan_t c);
    c.gate = 1'b0;
    if (c.on) begin
      c.count   = c.delay;
      c.running = 1'b1;
    end else begin
      c.count   = '0;
      c.running = 1'b0;
    end
    return c;
  endfunction

  // Gate takes the on flag at expiry, so a channel switched off mid-cycle fires low
  function automatic chan_t apply_tick(chan_t c);
    if (c.running) begin
      if (c.count <= 14'd1) begin
        c.count   = '0;
        c.running = 1'b0;
        c.gate    = c.on;
      end else begin
        c.count = c.count - 14'd1;
      end
    end
    return c;
  endfunction

  function automatic heater_result_t heater_outputs();
    heater_result_t r;
    r.oil_relay   = chan_state[OIL].on;
    r.water_relay = chan_state[WATER].on;
    r.oil_gate    = chan_state[OIL].gate;
    r.water_gate  = chan_state[WATER].gate;
    r.zero_en     = chan_state[OIL].on || chan_state[WATER].on;
    r.oil_temp    = chan_state[OIL].temp;
    r.water_temp  = chan_state[WATER].temp;
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------- monitor
  // Samples both channels at the rising edge; results are checked before the
  // expectation of the beat accepted at the same edge is added.
  always @(posedge clk) begin
    heater_result_t want;
    bit beat_in;
    bit beat_out;
    beat_in  = rst_n && in_tvalid && in_tready;
    beat_out = rst_n && out_tvalid && out_tready;
    if (beat_out) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("oil_relay", want.oil_relay, out_tdata[0]);
        compare_field("water_relay", want.water_relay, out_tdata[1]);
        compare_field("oil_gate", want.oil_gate, out_tdata[2]);
        compare_field("water_gate", want.water_gate, out_tdata[3]);
        compare_field("zero_detect_enable", want.zero_en, out_tdata[4]);
        compare_field("oil_temperature", int'($signed(want.oil_temp)),
                      int'($signed(out_tdata[23:5])));
        compare_field("water_temperature", int'($signed(want.water_temp)),
                      int'($signed(out_tdata[42:24])));
      end
    end
    if (beat_in) begin
      case (action_t'(in_tuser))
        ACT_SAMPLE: begin
          chan_state[OIL]   = apply_sample(chan_state[OIL], in_tdata[15:0]);
          chan_state[WATER] = apply_sample(chan_state[WATER], in_tdata[31:16]);
        end
        ACT_ZERO: begin
          chan_state[OIL]   = apply_zero_cross(chan_state[OIL]);
          chan_state[WATER] = apply_zero_cross(chan_state[WATER]);
        end
        ACT_TICK: begin
          chan_state[OIL]   = apply_tick(chan_state[OIL]);
          chan_state[WATER] = apply_tick(chan_state[WATER]);
        end
        default: ;  // unused code: state untouched, result still due
      endcase
      expected_results.push_back(heater_outputs());
    end
    in_taken = beat_in;
    if (beat_in || beat_out) quiet_cycles = 0;
    else quiet_cycles++;
    // watchdog: nothing moving on either side for too long
    if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bit keep_going();
    return calm || ($urandom_range(99) >= IDLE_PCT);
  endfunction

  // ---------------------------------------------------------------- driver
  // Next beat goes out on the falling edge once the current one is taken.
  always @(negedge clk) begin
    heater_beat_t nb;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_beats.size() > 0 && keep_going()) begin
        nb = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nb.water_res, nb.oil_res};
        in_tuser  <= nb.action;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // Random back-pressure plus one long hold while the sender keeps offering,
  // so the internal queue fills and in_tready drops.
  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && keep_going();
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_beat(action_t a, logic [15:0] oil_res, logic [15:0] water_res);
    heater_beat_t b;
    b.action    = a;
    b.oil_res   = oil_res;
    b.water_res = water_res;
    pending_beats.push_back(b);
  endtask

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) queue_beat(ACT_TICK, '0, '0);
  endtask

  // Block idle: nothing pending, nothing offered, nothing outstanding
  task automatic settle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_setpoint(logic addr, logic [13:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    if (addr == CFG_OIL_SP) chan_state[OIL].sp = value;
    else chan_state[WATER].sp = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Margin below setpoint in 1/32 degC; mostly short firing delays so gates
  // actually fire within a mains half cycle
  function automatic int pick_margin();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom_range(4000, RAMP_SPAN + 1);   // delay MIN
    if (roll < 70) return $urandom_range(RAMP_SPAN, 312);        // short ramp
    if (roll < 85) return -int'($urandom_range(4000, 1));        // channel off
    return $urandom_range(RAMP_SPAN, 0);                         // whole ramp
  endfunction

  function automatic logic [15:0] res_for(logic [SP_W-1:0] sp, int margin);
    int r;
    r = 1600 + (2 * int'(sp) - margin) / 5;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return 16'(r);
  endfunction

  // Mostly well-formed half cycles (sample, crossing, ticks, sometimes a
  // sample mid-cycle), the rest raw noise over all codes and resistance bits
  task automatic queue_random(int n);
    int added;
    int ticks;
    int split;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 12) begin
        queue_beat(action_t'($urandom_range(3)), 16'($urandom), 16'($urandom));
        added++;
      end else begin
        queue_beat(ACT_SAMPLE, res_for(chan_state[OIL].sp, pick_margin()),
                   res_for(chan_state[WATER].sp, pick_margin()));
        if ($urandom_range(19) != 0) queue_beat(ACT_ZERO, '0, '0);
        ticks = $urandom_range(45, 4);
        split = ($urandom_range(3) == 0) ? $urandom_range(ticks - 1, 1) : 0;
        queue_ticks(ticks - split);
        if (split > 0) begin
          queue_beat(ACT_SAMPLE, res_for(chan_state[OIL].sp, pick_margin()),
                     res_for(chan_state[WATER].sp, pick_margin()));
          queue_ticks(split);
        end
        added += ticks + 3;
      end
    end
  endtask

  initial begin
    logic [13:0] oil_sp;
    logic [13:0] water_sp;
    foreach (chan_state[i]) chan_state[i] = '{default: 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: oil set high, water at zero
    write_setpoint(CFG_OIL_SP, 14'd16000);
    write_setpoint(CFG_WATER_SP, 14'd0);
    queue_beat(ACT_TICK, '0, '0);                     // tick with nothing running
    queue_beat(ACT_ZERO, '0, '0);                     // crossing with both off
    queue_beat(ACT_NONE, 16'hFFFF, 16'hFFFF);         // unused code, ignored
    queue_beat(ACT_SAMPLE, 16'h0000, 16'hFFFF);       // resistance extremes
    queue_beat(ACT_ZERO, '0, '0);
    queue_ticks(11);                                  // oil fires on the tenth
    queue_beat(ACT_SAMPLE, 16'd8000, 16'd1600);       // exactly at setpoint
    queue_beat(ACT_SAMPLE, 16'd8001, 16'd1599);       // just above / just below
    queue_beat(ACT_SAMPLE, 16'd0, 16'd0);             // both far below
    queue_beat(ACT_ZERO, '0, '0);
    queue_ticks(3);
    queue_beat(ACT_SAMPLE, 16'hFFFF, 16'd0);          // oil switched off mid-cycle
    queue_ticks(7);                                   // oil fires low, water high
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin oil_sp = 14'h3FFF;  water_sp = 14'h3FFF;  end  // above range
        1:       begin oil_sp = 14'd0;     water_sp = 14'd16000; end
        3:       begin oil_sp = 14'd16000; water_sp = 14'd0;     end
        default: begin oil_sp = 14'($urandom); water_sp = 14'($urandom); end
      endcase
      write_setpoint(CFG_OIL_SP, oil_sp);
      write_setpoint(CFG_WATER_SP, water_sp);
      calm = (p == 2);   // one long stretch with no idling
      queue_random(ITEMS_PER_SET);
      settle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
